// File: sv/gkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkt_pkg: shared types and constants of the gated 2-D Kalman tracker
// Item layouts, mode and register codes, and Q16.16 saturation helpers.
// ----------------------------------------------------------------------------
package gkt_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        time_elapsed;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] cov_xx;
    logic signed [31:0] cov_xy;
    logic signed [31:0] cov_yx;
    logic signed [31:0] cov_yy;
  } gkt_in_t;

  typedef struct packed {
    logic signed [31:0] est_x_out;
    logic signed [31:0] est_y_out;
    logic signed [31:0] p_xx_out;
    logic signed [31:0] p_xy_out;
    logic signed [31:0] p_yx_out;
    logic signed [31:0] p_yy_out;
    logic               accepted;
    logic               is_initialised;
  } gkt_out_t;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_SET     = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  typedef enum logic [1:0] {
    KIND_PREDICT,
    KIND_UPDATE,
    KIND_SET,
    KIND_NOP
  } gkt_kind_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    gkt_kind_t kind;
    gkt_in_t   item;
  } gkt_cmd_t;

  localparam logic [1:0] CFG_NOISE_X   = 2'd0;
  localparam logic [1:0] CFG_NOISE_Y   = 2'd1;
  localparam logic [1:0] CFG_GATE      = 2'd2;
  localparam logic [1:0] CFG_HORIZON   = 2'd3;

  localparam logic [31:0] GATE_RESET    = 32'd196608;
  localparam logic [31:0] HORIZON_RESET = 32'd65536;

  localparam int ACC_W  = 52;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(Q_MAX)) r = Q_MAX;
    else if (v < ACC_W'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: sv/gated_kalman_tracker_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_kalman_tracker_2d: gated 2-D Kalman position tracker
// Two-entry front queue, then a sequenced back end with one shared
// multiply-accumulate unit and a 2-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// Set, seeding update and unused mode go from idle straight to the result stage.
// Predict runs a ratio division, then products in the shared unit (more once seeded).
// A seeded update runs four divisions for the inverse plus up to 29 products
// in the shared multiply-accumulate unit.
// One item is worked on at a time; the queue takes up to two more meanwhile.
// Synchronous active-low reset clears the filter state and restores register defaults.
module gated_kalman_tracker_2d (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gkt_pkg::gkt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gkt_pkg::gkt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gkt_pkg::*;

  logic     cmd_valid;
  logic     cmd_ready;
  gkt_cmd_t cmd;

  gkt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  gkt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/gkt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkt_front: input acceptance and classification
// Decodes the mode of each item and holds it in a two-entry queue for the
// back end, so the input side keeps moving while the back end computes, until both entries are full.
// ----------------------------------------------------------------------------
module gkt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gkt_pkg::gkt_in_t  in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output gkt_pkg::gkt_cmd_t cmd
);
  import gkt_pkg::*;

  gkt_cmd_t  q_r [2];
  logic      wr_ptr_r;
  logic      rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  gkt_kind_t kind_c;
  logic      push;
  logic      pop;

  always_comb begin
    case (in_data.mode)
      MODE_PREDICT: kind_c = KIND_PREDICT;
      MODE_UPDATE:  kind_c = KIND_UPDATE;
      MODE_SET:     kind_c = KIND_SET;
      default:      kind_c = KIND_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= '{kind: kind_c, item: in_data};
  end

endmodule

// File: sv/gkt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkt_div: unsigned restoring divider
// Produces a 48-bit quotient of a 48-bit dividend by a 32-bit divisor,
// two quotient bits per cycle.
// ----------------------------------------------------------------------------
module gkt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gkt_pkg::DIV_NW-1:0]  dividend,
  input  logic [gkt_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [gkt_pkg::DIV_NW-1:0]  quotient
);
  import gkt_pkg::*;

  localparam int STEPS = DIV_NW / 2;
  localparam int CW    = $clog2(STEPS);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] rem_nxt;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_NW-1:0] quo_nxt;
  logic [DIV_DW-1:0] dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  always_comb begin
    logic [DIV_DW:0] tmp;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      tmp     = {rem_nxt, quo_nxt[DIV_NW-1]};
      quo_nxt = {quo_nxt[DIV_NW-2:0], 1'b0};
      if (tmp >= {1'b0, dvs_r}) begin
        tmp        = tmp - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = tmp[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/gkt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkt_back: filter state and step sequencer
// Holds estimate, covariance and registers, and carries out predict, update
// and set steps with one shared multiply-accumulate unit and one divider.
// ----------------------------------------------------------------------------
module gkt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  gkt_pkg::gkt_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output gkt_pkg::gkt_out_t out_data
);
  import gkt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_ACC, S_FINISH
  } state_t;

  typedef enum logic [4:0] {
    O_S0, O_S1, O_S2, O_S3, O_I0, O_I1, O_I2, O_I3, O_Z0, O_Z1, O_W0, O_W1,
    O_P0, O_P1, O_P2, O_P3, O_K0, O_K1, O_K2, O_K3, O_M0, O_M1, O_M2, O_M3,
    O_PX, O_PY, O_FACT, O_R, O_NX, O_NY, O_G
  } opnd_t;

  typedef enum logic [2:0] {B_ZERO, B_ONE, B_EST0, B_EST1, B_P0, B_P3} bias_t;

  typedef enum logic [4:0] {
    D_NONE, D_DET, D_W0, D_W1, D_D2, D_K0, D_K1, D_K2, D_K3, D_EST0, D_EST1,
    D_NP0, D_NP1, D_NP2, D_NP3, D_FACT, D_P0, D_P3
  } dst_t;

  typedef enum logic [2:0] {DV_I0, DV_I1, DV_I2, DV_I3, DV_R} dsel_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  neg;
    logic  first;
    logic  last;
    bias_t bias;
    dst_t  dst;
  } mop_t;

  // Program counter marks of the micro-operation list.
  localparam logic [5:0] PC_DET_END   = 6'd1;
  localparam logic [5:0] PC_W         = 6'd2;
  localparam logic [5:0] PC_GATE      = 6'd8;
  localparam logic [5:0] PC_UPD_END   = 6'd28;
  localparam logic [5:0] PC_FACT      = 6'd29;
  localparam logic [5:0] PC_SCALE     = 6'd30;
  localparam logic [5:0] PC_SCALE_END = 6'd31;
  localparam logic [5:0] PC_NOISE_END = 6'd33;

  state_t             state_r;
  logic [5:0]         pc_r;
  dsel_t              dsel_r;
  gkt_in_t            item_r;
  logic               acc_flag_r;
  logic               seeded_r;
  logic signed [31:0] est_r [2];
  logic signed [31:0] p_r [4];
  logic signed [31:0] s_r [4];
  logic signed [31:0] inv_r [4];
  logic signed [31:0] z_r [2];
  logic signed [31:0] w_r [2];
  logic signed [31:0] k_r [4];
  logic signed [31:0] det_r;
  logic signed [31:0] d2_r;
  logic signed [31:0] fact_r;
  logic [23:0]        r_r;
  logic [31:0]        nx_r;
  logic [31:0]        ny_r;
  logic [31:0]        gate_r;
  logic [31:0]        hor_r;
  logic signed [65:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  gkt_out_t           out_r;
  logic               out_valid_r;

  mop_t                    op_c;
  logic signed [32:0]      a_c;
  logic signed [32:0]      b_c;
  logic signed [31:0]      m_c [4];
  logic signed [49:0]      term_c;
  logic signed [ACC_W-1:0] base_c;
  logic signed [ACC_W-1:0] sum_c;
  logic signed [31:0]      satv_c;
  logic signed [ACC_W-1:0] bias_c;
  logic signed [31:0]      num_c;
  logic [DIV_NW-1:0]       div_n;
  logic [DIV_DW-1:0]       div_d;
  logic                    div_start;
  logic                    div_done;
  logic [DIV_NW-1:0]       div_q;
  logic signed [31:0]      divres_c;

  function automatic mop_t mk(input opnd_t a, input opnd_t b, input logic ng,
                              input logic f, input logic l, input bias_t bs,
                              input dst_t d);
    return '{a, b, ng, f, l, bs, d};
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    return (v == Q_MIN) ? Q_MAX : -v;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [32:0] sx(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [32:0] pick(input opnd_t o);
    logic signed [32:0] v;
    case (o)
      O_S0:   v = sx(s_r[0]);
      O_S1:   v = sx(s_r[1]);
      O_S2:   v = sx(s_r[2]);
      O_S3:   v = sx(s_r[3]);
      O_I0:   v = sx(inv_r[0]);
      O_I1:   v = sx(inv_r[1]);
      O_I2:   v = sx(inv_r[2]);
      O_I3:   v = sx(inv_r[3]);
      O_Z0:   v = sx(z_r[0]);
      O_Z1:   v = sx(z_r[1]);
      O_W0:   v = sx(w_r[0]);
      O_W1:   v = sx(w_r[1]);
      O_P0:   v = sx(p_r[0]);
      O_P1:   v = sx(p_r[1]);
      O_P2:   v = sx(p_r[2]);
      O_P3:   v = sx(p_r[3]);
      O_K0:   v = sx(k_r[0]);
      O_K1:   v = sx(k_r[1]);
      O_K2:   v = sx(k_r[2]);
      O_K3:   v = sx(k_r[3]);
      O_M0:   v = sx(m_c[0]);
      O_M1:   v = sx(m_c[1]);
      O_M2:   v = sx(m_c[2]);
      O_M3:   v = sx(m_c[3]);
      O_PX:   v = sx(item_r.pos_x);
      O_PY:   v = sx(item_r.pos_y);
      O_FACT: v = sx(fact_r);
      O_R:    v = {9'd0, r_r};
      O_NX:   v = {1'b0, nx_r};
      O_NY:   v = {1'b0, ny_r};
      O_G:    v = {1'b0, gate_r};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Micro-operation list: each entry is one product term of a sum.
  always_comb begin
    case (pc_r)
      6'd0:  op_c = mk(O_S0, O_S3, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd1:  op_c = mk(O_S1, O_S2, 1'b1, 1'b0, 1'b1, B_ZERO, D_DET);
      6'd2:  op_c = mk(O_I0, O_Z0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd3:  op_c = mk(O_I1, O_Z1, 1'b0, 1'b0, 1'b1, B_ZERO, D_W0);
      6'd4:  op_c = mk(O_I2, O_Z0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd5:  op_c = mk(O_I3, O_Z1, 1'b0, 1'b0, 1'b1, B_ZERO, D_W1);
      6'd6:  op_c = mk(O_Z0, O_W0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd7:  op_c = mk(O_Z1, O_W1, 1'b0, 1'b0, 1'b1, B_ZERO, D_D2);
      6'd8:  op_c = mk(O_G,  O_G,  1'b0, 1'b1, 1'b1, B_ZERO, D_NONE);
      6'd9:  op_c = mk(O_P0, O_I0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd10: op_c = mk(O_P1, O_I2, 1'b0, 1'b0, 1'b1, B_ZERO, D_K0);
      6'd11: op_c = mk(O_P0, O_I1, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd12: op_c = mk(O_P1, O_I3, 1'b0, 1'b0, 1'b1, B_ZERO, D_K1);
      6'd13: op_c = mk(O_P2, O_I0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd14: op_c = mk(O_P3, O_I2, 1'b0, 1'b0, 1'b1, B_ZERO, D_K2);
      6'd15: op_c = mk(O_P2, O_I1, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd16: op_c = mk(O_P3, O_I3, 1'b0, 1'b0, 1'b1, B_ZERO, D_K3);
      6'd17: op_c = mk(O_K0, O_Z0, 1'b0, 1'b1, 1'b0, B_EST0, D_NONE);
      6'd18: op_c = mk(O_K1, O_Z1, 1'b0, 1'b0, 1'b1, B_ZERO, D_EST0);
      6'd19: op_c = mk(O_K2, O_Z0, 1'b0, 1'b1, 1'b0, B_EST1, D_NONE);
      6'd20: op_c = mk(O_K3, O_Z1, 1'b0, 1'b0, 1'b1, B_ZERO, D_EST1);
      6'd21: op_c = mk(O_M0, O_P0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd22: op_c = mk(O_M1, O_P2, 1'b0, 1'b0, 1'b1, B_ZERO, D_NP0);
      6'd23: op_c = mk(O_M0, O_P1, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd24: op_c = mk(O_M1, O_P3, 1'b0, 1'b0, 1'b1, B_ZERO, D_NP1);
      6'd25: op_c = mk(O_M2, O_P0, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd26: op_c = mk(O_M3, O_P2, 1'b0, 1'b0, 1'b1, B_ZERO, D_NP2);
      6'd27: op_c = mk(O_M2, O_P1, 1'b0, 1'b1, 1'b0, B_ZERO, D_NONE);
      6'd28: op_c = mk(O_M3, O_P3, 1'b0, 1'b0, 1'b1, B_ZERO, D_NP3);
      6'd29: op_c = mk(O_R,  O_R,  1'b1, 1'b1, 1'b1, B_ONE,  D_FACT);
      6'd30: op_c = mk(O_PX, O_FACT, 1'b0, 1'b1, 1'b1, B_ZERO, D_EST0);
      6'd31: op_c = mk(O_PY, O_FACT, 1'b0, 1'b1, 1'b1, B_ZERO, D_EST1);
      6'd32: op_c = mk(O_NX, O_NX, 1'b0, 1'b1, 1'b1, B_P0, D_P0);
      6'd33: op_c = mk(O_NY, O_NY, 1'b0, 1'b1, 1'b1, B_P3, D_P3);
      default: op_c = mk(O_S0, O_S0, 1'b0, 1'b1, 1'b1, B_ZERO, D_NONE);
    endcase
  end

  // The correction matrix I - K is formed from K as it is needed.
  always_comb begin
    m_c[0] = sat32(ACC_W'(32'sd65536) - ACC_W'(k_r[0]));
    m_c[1] = neg_sat(k_r[1]);
    m_c[2] = neg_sat(k_r[2]);
    m_c[3] = sat32(ACC_W'(32'sd65536) - ACC_W'(k_r[3]));
  end

  // The operand mux reads the working registers inside pick, so it must
  // re-evaluate whenever any of them changes.
  always_comb begin
    a_c = pick(op_c.a);
    b_c = pick(op_c.b);
  end

  always_comb begin
    case (op_c.bias)
      B_ONE:   bias_c = ACC_W'(32'sd65536);
      B_EST0:  bias_c = ACC_W'(est_r[0]);
      B_EST1:  bias_c = ACC_W'(est_r[1]);
      B_P0:    bias_c = ACC_W'(p_r[0]);
      B_P3:    bias_c = ACC_W'(p_r[3]);
      default: bias_c = '0;
    endcase
  end

  // Q16.16 product: the arithmetic shift by 16 rounds toward minus infinity.
  assign term_c = prod_r[65:16];
  assign base_c = op_c.first ? bias_c : acc_r;
  assign sum_c  = base_c + (op_c.neg ? -ACC_W'(term_c) : ACC_W'(term_c));
  assign satv_c = sat32(sum_c);

  // Divider operands: the inverse entries, or the elapsed-time ratio.
  always_comb begin
    case (dsel_r)
      DV_I0:   num_c = s_r[3];
      DV_I1:   num_c = neg_sat(s_r[1]);
      DV_I2:   num_c = neg_sat(s_r[2]);
      default: num_c = s_r[0];
    endcase
    if (dsel_r == DV_R) begin
      div_n = {item_r.time_elapsed, 16'd0};
      div_d = hor_r;
    end else begin
      div_n = {mag32(num_c), 16'd0};
      div_d = mag32(det_r);
    end
  end

  always_comb begin
    if (num_c[31] ^ det_r[31]) begin
      divres_c = (div_q > DIV_NW'(33'h0_8000_0000)) ? Q_MIN : -$signed(div_q[31:0]);
    end else begin
      divres_c = (div_q > DIV_NW'(32'h7FFF_FFFF)) ? Q_MAX : $signed(div_q[31:0]);
    end
  end

  assign div_start = (state_r == S_DIV_GO);

  gkt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r   <= '0;
      ny_r   <= '0;
      gate_r <= GATE_RESET;
      hor_r  <= HORIZON_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NOISE_X: nx_r   <= cfg_data;
        CFG_NOISE_Y: ny_r   <= cfg_data;
        CFG_GATE:    gate_r <= cfg_data;
        CFG_HORIZON: hor_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) prod_r <= a_c * b_c;
  end

  assign cmd_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seeded_r    <= 1'b0;
      acc_flag_r  <= 1'b0;
      pc_r        <= '0;
      dsel_r      <= DV_R;
      est_r[0]    <= '0;
      est_r[1]    <= '0;
      for (int i = 0; i < 4; i++) p_r[i] <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FINISH) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            item_r     <= cmd.item;
            acc_flag_r <= 1'b0;
            case (cmd.kind)
              KIND_SET: begin
                est_r[0] <= cmd.item.pos_x;
                est_r[1] <= cmd.item.pos_y;
                p_r[0]   <= cmd.item.cov_xx;
                p_r[1]   <= cmd.item.cov_xy;
                p_r[2]   <= cmd.item.cov_yx;
                p_r[3]   <= cmd.item.cov_yy;
                state_r  <= S_FINISH;
              end
              KIND_UPDATE: begin
                if (!seeded_r) begin
                  est_r[0]   <= cmd.item.pos_x;
                  est_r[1]   <= cmd.item.pos_y;
                  p_r[0]     <= cmd.item.cov_xx;
                  p_r[1]     <= cmd.item.cov_xy;
                  p_r[2]     <= cmd.item.cov_yx;
                  p_r[3]     <= cmd.item.cov_yy;
                  seeded_r   <= 1'b1;
                  acc_flag_r <= 1'b1;
                  state_r    <= S_FINISH;
                end else begin
                  z_r[0] <= sat32(ACC_W'(cmd.item.pos_x) - ACC_W'(est_r[0]));
                  z_r[1] <= sat32(ACC_W'(cmd.item.pos_y) - ACC_W'(est_r[1]));
                  s_r[0] <= sat32(ACC_W'(p_r[0]) + ACC_W'(cmd.item.cov_xx));
                  s_r[1] <= sat32(ACC_W'(p_r[1]) + ACC_W'(cmd.item.cov_xy));
                  s_r[2] <= sat32(ACC_W'(p_r[2]) + ACC_W'(cmd.item.cov_yx));
                  s_r[3] <= sat32(ACC_W'(p_r[3]) + ACC_W'(cmd.item.cov_yy));
                  pc_r    <= '0;
                  state_r <= S_MUL;
                end
              end
              KIND_PREDICT: begin
                if (hor_r == '0) begin
                  fact_r  <= Q_MIN;
                  pc_r    <= PC_SCALE;
                  state_r <= S_MUL;
                end else begin
                  dsel_r  <= DV_R;
                  state_r <= S_DIV_GO;
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            case (dsel_r)
              DV_R: begin
                // A ratio of 2^24 or more drives the decay factor to the floor.
                if (div_q[DIV_NW-1:24] != '0) begin
                  fact_r <= Q_MIN;
                  pc_r   <= PC_SCALE;
                end else begin
                  r_r  <= div_q[23:0];
                  pc_r <= PC_FACT;
                end
                state_r <= S_MUL;
              end
              DV_I0: begin
                inv_r[0] <= divres_c;
                dsel_r   <= DV_I1;
                state_r  <= S_DIV_GO;
              end
              DV_I1: begin
                inv_r[1] <= divres_c;
                dsel_r   <= DV_I2;
                state_r  <= S_DIV_GO;
              end
              DV_I2: begin
                inv_r[2] <= divres_c;
                dsel_r   <= DV_I3;
                state_r  <= S_DIV_GO;
              end
              default: begin
                inv_r[3] <= divres_c;
                pc_r     <= PC_W;
                state_r  <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          acc_r <= sum_c;
          if (op_c.last) begin
            case (op_c.dst)
              D_DET:  det_r    <= satv_c;
              D_W0:   w_r[0]   <= satv_c;
              D_W1:   w_r[1]   <= satv_c;
              D_D2:   d2_r     <= satv_c;
              D_K0:   k_r[0]   <= satv_c;
              D_K1:   k_r[1]   <= satv_c;
              D_K2:   k_r[2]   <= satv_c;
              D_K3:   k_r[3]   <= satv_c;
              D_EST0: est_r[0] <= satv_c;
              D_EST1: est_r[1] <= satv_c;
              D_NP0:  s_r[0]   <= satv_c;
              D_NP1:  s_r[1]   <= satv_c;
              D_NP2:  s_r[2]   <= satv_c;
              D_NP3:  s_r[3]   <= satv_c;
              D_FACT: fact_r   <= satv_c;
              D_P0:   p_r[0]   <= satv_c;
              D_P3:   p_r[3]   <= satv_c;
              default: ;
            endcase
          end
          if (pc_r == PC_DET_END) begin
            // A singular innovation covariance rejects the observation.
            if (satv_c == '0) begin
              state_r <= S_FINISH;
            end else begin
              dsel_r  <= DV_I0;
              state_r <= S_DIV_GO;
            end
          end else if (pc_r == PC_GATE) begin
            // The sum here is the squared threshold, which never saturates.
            if (!d2_r[31] && (DIV_NW'(unsigned'(d2_r)) < sum_c[DIV_NW-1:0])) begin
              pc_r    <= pc_r + 6'd1;
              state_r <= S_MUL;
            end else begin
              state_r <= S_FINISH;
            end
          end else if (pc_r == PC_UPD_END) begin
            p_r[0]     <= s_r[0];
            p_r[1]     <= s_r[1];
            p_r[2]     <= s_r[2];
            p_r[3]     <= satv_c;
            acc_flag_r <= 1'b1;
            state_r    <= S_FINISH;
          end else if (pc_r == PC_SCALE_END) begin
            if (seeded_r) begin
              pc_r    <= pc_r + 6'd1;
              state_r <= S_MUL;
            end else begin
              state_r <= S_FINISH;
            end
          end else if (pc_r == PC_NOISE_END) begin
            state_r <= S_FINISH;
          end else begin
            pc_r    <= pc_r + 6'd1;
            state_r <= S_MUL;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_r <= '{est_r[0], est_r[1], p_r[0], p_r[1], p_r[2], p_r[3],
                       acc_flag_r, seeded_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accepted_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.accepted |-> out_r.is_initialised)
    else $error("accepted result reported on an unseeded filter");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_GO |-> div_d != '0)
    else $error("divider started with a zero divisor");

  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |=> state_r != S_IDLE)
    else $error("taken item did not start a step");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && out_valid_r && !out_ready |=> state_r == S_FINISH)
    else $error("result register overwritten before it was taken");

endmodule
